@@ rtl/hmqs_pkg.sv @@
// Heightmap quad shader: shared types, constants and palette tables.
// No dependencies; every other file of the block depends on this package.
package hmqs_pkg;

  localparam int unsigned NumW  = 37;   // dividend width of the shared divider
  localparam int unsigned DenW  = 34;   // divisor width
  localparam int unsigned QuoW  = 21;   // quotient width
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  localparam logic [10:0] MinFlat  = 11'd461;   // 0.45
  localparam logic [10:0] OneQ10   = 11'd1024;
  localparam logic [10:0] DelayWat = 11'd717;   // 0.7
  localparam logic [10:0] DelayLnd = 11'd819;   // 0.8

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWaterMode  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSnowLevel  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgGrassLevel = 8'd3;

  typedef enum logic [1:0] {
    PalWater = 2'd0,
    PalSnow  = 2'd1,
    PalGrass = 2'd2,
    PalSand  = 2'd3
  } palette_e;

  // corner codes: bit 0 selects the right column, bit 1 the bottom row
  typedef enum logic [1:0] {
    CornerTL = 2'd0,
    CornerTR = 2'd1,
    CornerBL = 2'd2,
    CornerBR = 2'd3
  } corner_e;

  typedef struct packed {
    logic signed [15:0] height_top_left;
    logic signed [15:0] height_top_right;
    logic signed [15:0] height_bottom_left;
    logic signed [15:0] height_bottom_right;
    logic [9:0]         quad_row;
    logic [9:0]         quad_col;
  } quad_t;

  typedef struct packed {
    logic signed [11:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [11:0] pos_z;
    logic [10:0]        red;
    logic [10:0]        green;
    logic [10:0]        blue;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] value;
  } cfg_word_t;

  // Steep color of a palette, component 0 red .. 2 blue.
  function automatic logic [10:0] steep_color(palette_e pal, logic [1:0] comp);
    logic [10:0] c;
    c = 11'd0;
    if (pal == PalWater) begin
      unique case (comp)
        2'd0:    c = 11'd102;
        2'd1:    c = 11'd205;
        default: c = 11'd410;
      endcase
    end else begin
      unique case (comp)
        2'd0:    c = 11'd461;
        2'd1:    c = 11'd410;
        default: c = 11'd358;
      endcase
    end
    return c;
  endfunction

  // Flat color of a palette.
  function automatic logic [10:0] flat_color(palette_e pal, logic [1:0] comp);
    logic [10:0] c;
    c = 11'd0;
    unique case (pal)
      PalWater: begin
        unique case (comp)
          2'd0:    c = 11'd205;
          2'd1:    c = 11'd410;
          default: c = 11'd819;
        endcase
      end
      PalSnow: c = 11'd1024;
      PalGrass: begin
        unique case (comp)
          2'd0:    c = 11'd307;
          2'd1:    c = 11'd614;
          default: c = 11'd205;
        endcase
      end
      default: begin
        unique case (comp)
          2'd0:    c = 11'd819;
          2'd1:    c = 11'd819;
          default: c = 11'd717;
        endcase
      end
    endcase
    return c;
  endfunction

  // Corner of each of the six vertices for the two diagonal phases.
  function automatic corner_e vtx_corner(logic phase, logic [2:0] idx);
    corner_e c;
    c = CornerTL;
    if (phase) begin
      unique case (idx)
        3'd0:    c = CornerTL;
        3'd1:    c = CornerTR;
        3'd2:    c = CornerBL;
        3'd3:    c = CornerTR;
        3'd4:    c = CornerBR;
        default: c = CornerBL;
      endcase
    end else begin
      unique case (idx)
        3'd0:    c = CornerTL;
        3'd1:    c = CornerBR;
        3'd2:    c = CornerBL;
        3'd3:    c = CornerTR;
        3'd4:    c = CornerBR;
        default: c = CornerTL;
      endcase
    end
    return c;
  endfunction

endpackage

@@ rtl/hmqs_if.sv @@
// Heightmap quad shader: valid/ready channel interfaces.
// Depends on hmqs_pkg for the payload types.
interface hmqs_in_if;
  logic          valid;
  logic          ready;
  hmqs_pkg::quad_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hmqs_out_if;
  logic              valid;
  logic              ready;
  hmqs_pkg::vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hmqs_cfg_if;
  logic                valid;
  logic                ready;
  hmqs_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/hmqs_div.sv @@
// Heightmap quad shader: shared restoring divider, one quotient bit a cycle.
// Depends on hmqs_pkg for the operand widths.
module hmqs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hmqs_pkg::NumW-1:0]  num_i,
  input  logic [hmqs_pkg::DenW-1:0]  den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [hmqs_pkg::QuoW-1:0]  quot_o
);
  import hmqs_pkg::*;

  localparam int unsigned ShW  = DenW + QuoW - 1;
  localparam int unsigned CntW = $clog2(QuoW);

  logic [NumW-1:0] rem_q, rem_d;
  logic [ShW-1:0]  dsh_q, dsh_d;
  logic [QuoW-1:0] quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic            ge;

  // Compare the remainder against the shifted divisor.
  assign ge = {{(ShW-NumW){1'b0}}, rem_q} >= dsh_q;

  // Load on start, then retire one quotient bit a cycle.
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = {den_i, {(QuoW-1){1'b0}}};
      quot_d = '0;
      cnt_d  = CntW'(QuoW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q[NumW-1:0];
      end
      quot_d = {quot_q[QuoW-2:0], ge};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
`endif

endmodule

@@ rtl/heightmap_quad_shader_core.sv @@
// Heightmap quad shader top level: sequencer, flatness root and color blend.
// Depends on hmqs_pkg, the hmqs_*_if interfaces and hmqs_div.
//
// Usage: one quad word (four corner heights, row, column) enters on in_i.
// The block splits it into two triangles along a diagonal that alternates
// from quad to quad, starting with the top-right/bottom-left edge split
// after reset. It then sends six vertex words on out_o, the sixth marked
// with last_vertex. in_i.ready is high only while the block is idle.
// Per triangle the shared divider runs twice (inverse of the squared slope
// norm, then the flatness blend factor, the second skipped on steep
// triangles), an 11-step square root runs between them, and StMix and
// StScal blend and scale the three color components in turn. Once both
// triangles are done it sends one vertex a cycle while out_o.ready stays
// high; a stalled receiver simply holds the vertex.
// cfg_i writes registers at any time (ready is tied high); writes are
// meant to happen while idle. Reset loads the default registers and the
// first diagonal phase.
module heightmap_quad_shader_core #(
  parameter int unsigned MAX_GRID_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hmqs_cfg_if.sink    cfg_i,
  hmqs_in_if.sink     in_i,
  hmqs_out_if.source  out_o
);
  import hmqs_pkg::*;

  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StSqr  = 10'b00_0000_0010,
    StSum  = 10'b00_0000_0100,
    StDivF = 10'b00_0000_1000,
    StRoot = 10'b00_0001_0000,
    StPrep = 10'b00_0010_0000,
    StDivA = 10'b00_0100_0000,
    StMix  = 10'b00_1000_0000,
    StScal = 10'b01_0000_0000,
    StEmit = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic               water_q;
  logic [10:0]        gw_q;
  logic signed [15:0] snow_q, grass_q;
  logic               phase_q;

  // datapath registers
  quad_t              quad_q;
  logic               half_q;     // triangle being worked on
  logic [31:0]        sq1_q, sq2_q;
  logic signed [17:0] hsum_q;
  palette_e           pal_q;
  logic [10:0]        root_q;
  logic [3:0]         rbit_q;
  logic [10:0]        flat_q;
  logic [10:0]        adj_q;
  logic [21:0]        mix_q;
  logic [1:0]         comp_q;
  logic [2:0]         vtx_q;
  logic [10:0]        col_q [2][3];

  // divider hookup
  logic             div_start, div_busy, div_done;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic [QuoW-1:0]  div_quot;

  hmqs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Configuration writes, grid width clamped to its legal range.
  logic [12:0] gw_wr;
  assign gw_wr       = {2'b00, cfg_i.data.value[10:0]};
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_q <= 1'b0;
      gw_q    <= 11'd256;
      snow_q  <= 16'sd5120;
      grass_q <= 16'sd1024;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CfgWaterMode:  water_q <= cfg_i.data.value[0];
        CfgGridWidth: begin
          if (gw_wr < 13'd2) begin
            gw_q <= 11'd2;
          end else if (gw_wr > 13'(MAX_GRID_WIDTH)) begin
            gw_q <= 11'(MAX_GRID_WIDTH);
          end else begin
            gw_q <= gw_wr[10:0];
          end
        end
        CfgSnowLevel:  snow_q  <= cfg_i.data.value;
        CfgGrassLevel: grass_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Pick slope differences and the height sum of the current triangle.
  logic signed [16:0] e_tl, e_tr, e_bl, e_br, d1, d2;
  logic signed [17:0] tsum;
  logic signed [33:0] p1, p2;

  assign e_tl = {quad_q.height_top_left[15], quad_q.height_top_left};
  assign e_tr = {quad_q.height_top_right[15], quad_q.height_top_right};
  assign e_bl = {quad_q.height_bottom_left[15], quad_q.height_bottom_left};
  assign e_br = {quad_q.height_bottom_right[15], quad_q.height_bottom_right};

  always_comb begin
    unique case ({phase_q, half_q})
      2'b10: begin
        d1 = e_tl - e_tr;
        d2 = e_tl - e_bl;
        tsum = 18'(e_tl) + 18'(e_tr) + 18'(e_bl);
      end
      2'b11: begin
        d1 = e_bl - e_br;
        d2 = e_tr - e_br;
        tsum = 18'(e_tr) + 18'(e_br) + 18'(e_bl);
      end
      2'b00: begin
        d1 = e_bl - e_br;
        d2 = e_tl - e_bl;
        tsum = 18'(e_tl) + 18'(e_br) + 18'(e_bl);
      end
      default: begin
        d1 = e_tl - e_tr;
        d2 = e_tr - e_br;
        tsum = 18'(e_tr) + 18'(e_br) + 18'(e_tl);
      end
    endcase
  end

  assign p1 = d1 * d1;
  assign p2 = d2 * d2;

  // Palette from the exact mean: sum of three heights against three times each level.
  logic signed [17:0] snow3, grass3;
  palette_e           pal_new;
  assign snow3  = 18'(snow_q) + 18'(snow_q) + 18'(snow_q);
  assign grass3 = 18'(grass_q) + 18'(grass_q) + 18'(grass_q);

  always_comb begin
    priority if (water_q)         pal_new = PalWater;
    else if (hsum_q > snow3)      pal_new = PalSnow;
    else if (hsum_q > grass3)     pal_new = PalGrass;
    else                          pal_new = PalSand;
  end

  // Square root step, flatness clamp and blend factor setup.
  logic [10:0] cand;
  logic [21:0] cand_sq;
  logic [10:0] flat_new, delay, span;
  logic [9:0]  over;
  logic [33:0] norm_sq;

  assign cand     = root_q | (11'd1 << rbit_q);
  assign cand_sq  = cand * cand;
  assign flat_new = (root_q < MinFlat) ? MinFlat : root_q;
  assign delay    = (pal_q == PalWater) ? DelayWat : DelayLnd;
  assign span     = OneQ10 - delay;
  assign over     = 10'(flat_new - delay);
  assign norm_sq  = 34'(32'h0001_0000) + 34'(sq1_q) + 34'(sq2_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = NumW'(1) << (NumW - 1);
    div_den   = norm_sq;
    if (state_q == StSum) begin
      div_start = 1'b1;
    end else if (state_q == StPrep && flat_new > delay) begin
      div_start = 1'b1;
      div_num   = NumW'({over, 10'd0});
      div_den   = DenW'(span);
    end
  end

  // Blend steep and flat colors, then scale by flatness with saturation.
  logic [10:0] c_steep, c_flat, inv_adj;
  logic [21:0] mix_new;
  logic [32:0] scaled;
  logic [10:0] col_new;

  assign c_steep = steep_color(pal_q, comp_q);
  assign c_flat  = flat_color(pal_q, comp_q);
  assign inv_adj = OneQ10 - adj_q;
  assign mix_new = 22'(inv_adj * c_steep) + 22'(adj_q * c_flat);
  assign scaled  = mix_q * flat_q;
  assign col_new = (scaled[32:20] > 13'd1024) ? OneQ10 : scaled[30:20];

  logic in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) state_d = StSqr;
      StSqr:  state_d = StSum;
      StSum:  state_d = StDivF;
      StDivF: if (div_done) state_d = StRoot;
      StRoot: if (rbit_q == 4'd0) state_d = StPrep;
      StPrep: state_d = (flat_new > delay) ? StDivA : StMix;
      StDivA: if (div_done) state_d = StMix;
      StMix:  state_d = StScal;
      StScal: begin
        if (comp_q == 2'd2) begin
          state_d = half_q ? StEmit : StSqr;
        end else begin
          state_d = StMix;
        end
      end
      StEmit: if (out_fire && vtx_q == 3'd5) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= 1'b1;
      half_q  <= 1'b0;
      comp_q  <= 2'd0;
      vtx_q   <= 3'd0;
      rbit_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin
          half_q <= 1'b0;
          vtx_q  <= 3'd0;
        end
        StDivF: rbit_q <= 4'd10;
        StRoot: rbit_q <= rbit_q - 4'd1;
        StPrep: comp_q <= 2'd0;
        StScal: begin
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            half_q <= 1'b1;
          end
        end
        StEmit: begin
          if (out_fire) begin
            vtx_q <= vtx_q + 3'd1;
            if (vtx_q == 3'd5) begin
              phase_q <= ~phase_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      quad_q <= in_i.data;
    end
    if (state_q == StSqr) begin
      sq1_q  <= p1[31:0];
      sq2_q  <= p2[31:0];
      hsum_q <= tsum;
    end
    if (state_q == StSum) begin
      pal_q <= pal_new;
    end
    if (state_q == StDivF) begin
      root_q <= 11'd0;
    end
    if (state_q == StRoot && {11'd0, cand_sq} <= {12'd0, div_quot}) begin
      root_q <= cand;
    end
    if (state_q == StPrep) begin
      flat_q <= flat_new;
      adj_q  <= 11'd0;
    end
    if (state_q == StDivA && div_done) begin
      adj_q <= div_quot[10:0];
    end
    if (state_q == StMix) begin
      mix_q <= mix_new;
    end
    if (state_q == StScal) begin
      col_q[half_q][comp_q] <= col_new;
    end
  end

  // Vertex word from the stored quad and colors.
  logic [9:0]  org_half;
  logic [11:0] x0, z0;
  corner_e     corner;
  logic        vhalf;

  assign org_half = 10'((gw_q - 11'd1) >> 1);
  assign x0       = {2'b00, quad_q.quad_col} - {2'b00, org_half};
  assign z0       = {2'b00, quad_q.quad_row} - {2'b00, org_half};
  assign corner   = vtx_corner(phase_q, vtx_q);
  assign vhalf    = (vtx_q >= 3'd3);

  always_comb begin
    unique case (corner)
      CornerTL: out_o.data.pos_y = quad_q.height_top_left;
      CornerTR: out_o.data.pos_y = quad_q.height_top_right;
      CornerBL: out_o.data.pos_y = quad_q.height_bottom_left;
      default:  out_o.data.pos_y = quad_q.height_bottom_right;
    endcase
  end

  assign out_o.data.pos_x       = corner[0] ? x0 + 12'd1 : x0;
  assign out_o.data.pos_z       = corner[1] ? z0 + 12'd1 : z0;
  assign out_o.data.red         = col_q[vhalf][0];
  assign out_o.data.green       = col_q[vhalf][1];
  assign out_o.data.blue        = col_q[vhalf][2];
  assign out_o.data.last_vertex = (vtx_q == 3'd5);
  assign out_o.valid            = (state_q == StEmit);
  assign in_i.ready             = (state_q == StIdle);

`ifndef SYNTH
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("input taken while emitting");
  a_emit_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> half_q) else $error("emit before second triangle");
  a_phase_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_q) |-> $past(out_fire && vtx_q == 3'd5))
    else $error("diagonal phase changed outside quad end");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivF || state_q == StDivA) && !div_busy |-> div_done)
    else $error("sequencer waits on an idle divider");
`endif

endmodule

@@ verif/heightmap_quad_shader_core_test.sv @@
// Testbench for heightmap_quad_shader_core: directed and random quads, checked
// against an in-bench predictor of vertex positions, palettes and flatness shading.
// Depends on hmqs_pkg, the hmqs_*_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module heightmap_quad_shader_core_test;
  import hmqs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hmqs_cfg_if cfg_ch ();
  hmqs_in_if  quad_ch ();
  hmqs_out_if vtx_ch ();

  heightmap_quad_shader_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (quad_ch.sink),
    .out_o (vtx_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the block's registers and diagonal state
  logic        water_q;
  int          width_q;
  int          snow_q;
  int          grass_q;
  logic        phase_q;
  vertex_t     vertex_queue[$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // flatness: largest f with f^2 * (65536 + d1^2 + d2^2) <= 2^36, floor 0.45
  function automatic int unsigned flatness(int d1, int d2);
    longint unsigned s, lo, hi, mid;
    s  = 65536 + longint'(d1) * d1 + longint'(d2) * d2;
    lo = 0;
    hi = 1024;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * s <= (64'd1 << 36)) lo = mid;
      else hi = mid - 1;
    end
    return (lo < MinFlat) ? MinFlat : int'(lo);
  endfunction

  function automatic palette_e pick_palette(int sum);
    if (water_q) return PalWater;
    if (longint'(sum) > 3 * longint'(snow_q)) return PalSnow;
    if (longint'(sum) > 3 * longint'(grass_q)) return PalGrass;
    return PalSand;
  endfunction

  function automatic vertex_t shade_vertex(int x, int y, int z, int unsigned f,
                                           palette_e pal, logic last);
    vertex_t v;
    int unsigned dl, adj;
    longint unsigned mix, c;
    dl  = (pal == PalWater) ? DelayWat : DelayLnd;
    adj = (f > dl) ? ((f - dl) * 1024) / (1024 - dl) : 0;
    v.pos_x = x[11:0];
    v.pos_y = y[15:0];
    v.pos_z = z[11:0];
    for (int k = 0; k < 3; k++) begin
      mix = longint'(1024 - adj) * steep_color(pal, k[1:0]) +
            longint'(adj) * flat_color(pal, k[1:0]);
      c = (mix * f) >> 20;
      if (c > 1024) c = 1024;
      if (k == 0) v.red = c[10:0];
      else if (k == 1) v.green = c[10:0];
      else v.blue = c[10:0];
    end
    v.last_vertex = last;
    return v;
  endfunction

  // work out the six vertices of one quad and advance the diagonal
  task automatic predict_quad(quad_t q);
    int tl, tr, bl, br, org, x0, z0;
    int unsigned f1, f2;
    palette_e p1, p2;
    tl  = q.height_top_left;
    tr  = q.height_top_right;
    bl  = q.height_bottom_left;
    br  = q.height_bottom_right;
    org = (1 - width_q) / 2;
    x0  = org + q.quad_col;
    z0  = org + q.quad_row;
    if (phase_q) begin
      f1 = flatness(tl - tr, tl - bl);
      f2 = flatness(bl - br, tr - br);
      p1 = pick_palette(tl + tr + bl);
      p2 = pick_palette(tr + br + bl);
      vertex_queue.push_back(shade_vertex(x0, tl, z0, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, tr, z0, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0, bl, z0 + 1, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, tr, z0, f2, p2, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, br, z0 + 1, f2, p2, 1'b0));
      vertex_queue.push_back(shade_vertex(x0, bl, z0 + 1, f2, p2, 1'b1));
    end else begin
      f1 = flatness(bl - br, tl - bl);
      f2 = flatness(tl - tr, tr - br);
      p1 = pick_palette(tl + br + bl);
      p2 = pick_palette(tr + br + tl);
      vertex_queue.push_back(shade_vertex(x0, tl, z0, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, br, z0 + 1, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0, bl, z0 + 1, f1, p1, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, tr, z0, f2, p2, 1'b0));
      vertex_queue.push_back(shade_vertex(x0 + 1, br, z0 + 1, f2, p2, 1'b0));
      vertex_queue.push_back(shade_vertex(x0, tl, z0, f2, p2, 1'b1));
    end
    phase_q = ~phase_q;
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // write one register and mirror it into the shadow copy
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgWaterMode:  water_q = val[0];
      CfgGridWidth: begin
        width_q = val[10:0];
        if (width_q < 2) width_q = 2;
        if (width_q > 1024) width_q = 1024;
      end
      CfgSnowLevel:  snow_q = $signed(val);
      CfgGrassLevel: grass_q = $signed(val);
      default: ;
    endcase
    // drop valid before the next word
    @(posedge clk_i);
  endtask

  // send one quad word, predicting at acceptance
  task automatic send_quad(quad_t q);
    // the previous word drops valid at its accepting edge, so idle past it
    idle_cycles(gap_length() + 1);
    quad_ch.valid <= 1'b1;
    quad_ch.data  <= q;
    do @(posedge clk_i); while (!quad_ch.ready);
    predict_quad(q);
    quad_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (vertex_queue.size() != 0) @(posedge clk_i);
    idle_cycles(5);
  endtask

  function automatic quad_t make_quad(int tl, int tr, int bl, int br, int row, int col);
    quad_t q;
    q.height_top_left     = tl[15:0];
    q.height_top_right    = tr[15:0];
    q.height_bottom_left  = bl[15:0];
    q.height_bottom_right = br[15:0];
    q.quad_row            = row[9:0];
    q.quad_col            = col[9:0];
    return q;
  endfunction

  function automatic quad_t random_quad(int spread);
    int base;
    base = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                     : int'($urandom_range(0, 4000)) - 1000;
    if (spread == 0)
      return make_quad($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 1023), $urandom_range(0, 1023));
    return make_quad(base + int'($urandom_range(0, 2 * spread)) - spread,
                     base + int'($urandom_range(0, 2 * spread)) - spread,
                     base + int'($urandom_range(0, 2 * spread)) - spread,
                     base + int'($urandom_range(0, 2 * spread)) - spread,
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  // height extremes, flat and steep quads, palette thresholds
  task automatic test_directed();
    send_quad(make_quad(0, 0, 0, 0, 0, 0));
    send_quad(make_quad(32767, 32767, 32767, 32767, 1022, 1022));
    send_quad(make_quad(-32768, -32768, -32768, -32768, 0, 1022));
    send_quad(make_quad(32767, -32768, -32768, 32767, 1022, 0));
    send_quad(make_quad(-32768, 32767, 32767, -32768, 1023, 1023));
    send_quad(make_quad(5120, 5120, 5120, 5120, 10, 20));
    send_quad(make_quad(5121, 5120, 5120, 5121, 10, 20));
    send_quad(make_quad(1024, 1024, 1024, 1024, 3, 4));
    send_quad(make_quad(1025, 1024, 1024, 1025, 3, 4));
    send_quad(make_quad(256, 0, 128, 64, 127, 128));
    send_quad(make_quad(100, 90, 80, 70, 255, 0));
    send_quad(make_quad(0, 300, 600, 900, 511, 512));
    wait_idle();
  endtask

  // palettes, grid widths and levels across their extremes
  task automatic test_register_sweep();
    write_reg(CfgWaterMode, 16'd1);
    write_reg(CfgGridWidth, 16'd2);
    for (int i = 0; i < 4; i++) send_quad(random_quad(200));
    wait_idle();
    write_reg(CfgWaterMode, 16'd0);
    write_reg(CfgGridWidth, 16'd1024);
    write_reg(CfgSnowLevel, 16'h8000);
    write_reg(CfgGrassLevel, 16'h7FFF);
    for (int i = 0; i < 4; i++) send_quad(random_quad(200));
    wait_idle();
    write_reg(CfgGridWidth, 16'd0);
    write_reg(CfgSnowLevel, 16'h7FFF);
    write_reg(CfgGrassLevel, 16'h8000);
    for (int i = 0; i < 3; i++) send_quad(random_quad(300));
    wait_idle();
    write_reg(CfgGridWidth, 16'h07FF);
    write_reg(8'd9, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_quad(random_quad(0));
    wait_idle();
  endtask

  // random quads, mostly gentle terrain, some wild; settings change between phases
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgWaterMode, $urandom_range(0, 3) == 0);
      write_reg(CfgGridWidth, $urandom_range(0, 2047));
      write_reg(CfgSnowLevel, $urandom_range(1000, 6000));
      write_reg(CfgGrassLevel, $urandom_range(0, 65535));
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(0, 3))
          0: send_quad(random_quad(0));
          1: send_quad(random_quad(2000));
          default: send_quad(random_quad(150));
        endcase
      end
      // hold off until every vertex of this phase has arrived
      wait_idle();
    end
  endtask

  // receiver: random stalls, compare each vertex with the oldest prediction
  initial begin
    vtx_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (vtx_ch.valid && vtx_ch.ready) begin
        if (vertex_queue.size() == 0) begin
          $display("%0t: unexpected vertex %p", $time, vtx_ch.data);
          fail_count++;
        end else begin
          vertex_t want;
          want = vertex_queue.pop_front();
          if (want !== vtx_ch.data) begin
            $display("%0t: vertex mismatch expected %p actual %p", $time, want,
                     vtx_ch.data);
            fail_count++;
          end
        end
      end
      vtx_ch.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 30) == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    quad_ch.valid = 1'b0;
    quad_ch.data  = '0;
    water_q = 1'b0;
    width_q = 256;
    snow_q  = 5120;
    grass_q = 1024;
    phase_q = 1'b1;
    idle_cycles(5);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_random();
    wait_idle();
    idle_cycles(DrainCycles);
    if (fail_count == 0 && vertex_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
